### design/pitt_pkg.sv
package pitt_pkg;

   // Register indexes on the configuration port
   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_A_X = 3'd0,
      CSR_A_Y = 3'd1,
      CSR_B_X = 3'd2,
      CSR_B_Y = 3'd3,
      CSR_C_X = 3'd4,
      CSR_C_Y = 3'd5,
      CSR_TOL = 3'd6
   } pitt_csr_type;

   localparam int TOL_BITS = 8;
   localparam int EPSQ_BITS = 2 * TOL_BITS;
   // 0.1 in Q.8, rounded
   localparam logic [TOL_BITS-1:0] TOL_RESET = 8'd26;

   localparam int RSP_W = 8;

   // Stage advance strobes shared by the per-edge datapaths
   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } pitt_adv_type;

endpackage

### design/pitt_edge.sv
module pitt_edge #(
   parameter int COORD_BITS = 24,
   localparam int DW = COORD_BITS + 1,
   localparam int PW = 2 * DW,
   localparam int SW = PW + 1,
   localparam int CW = COORD_BITS + 9,
   localparam int RW = SW - 1 + pitt_pkg::EPSQ_BITS
) (
   input  logic                             clock,
   input  pitt_pkg::pitt_adv_type           adv,
   input  logic signed [DW-1:0]             qs_x,
   input  logic signed [DW-1:0]             qs_y,
   input  logic signed [DW-1:0]             qe_x,
   input  logic signed [DW-1:0]             qe_y,
   input  logic signed [DW-1:0]             ev_x,
   input  logic signed [DW-1:0]             ev_y,
   input  logic signed [SW-1:0]             len2,
   input  logic [pitt_pkg::EPSQ_BITS-1:0]   epsq,
   input  logic [RW-1:0]                    rhs,
   output logic                             near
);
   import pitt_pkg::*;

   localparam int MW = (2 * CW > RW) ? 2 * CW : RW;

   logic signed [PW-1:0] dp1_ff, dp2_ff, cp1_ff, cp2_ff;
   logic signed [PW-1:0] ss1_ff, ss2_ff, se1_ff, se2_ff;

   logic signed [SW-1:0] dot_in, cr_in, sqs_in, sqe_in;
   logic signed [SW-1:0] cr_ff, sqs_ff, sqe_ff;
   logic                 far_in, far4_ff, neg4_ff;

   logic [SW-1:0]        cmag_in;
   logic [CW-1:0]        cabs_ff;
   logic                 far5_ff, neg5_ff, nears5_ff, neare5_ff, cbig5_ff;

   logic [2*CW-1:0]      csq_ff;
   logic                 far6_ff, neg6_ff, nears6_ff, neare6_ff, cbig6_ff;

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         dp1_ff <= qs_x * ev_x;
         dp2_ff <= qs_y * ev_y;
         cp1_ff <= ev_x * qs_y;
         cp2_ff <= ev_y * qs_x;
         ss1_ff <= qs_x * qs_x;
         ss2_ff <= qs_y * qs_y;
         se1_ff <= qe_x * qe_x;
         se2_ff <= qe_y * qe_y;
      end
   end

   always_comb begin
      dot_in = SW'(dp1_ff) + SW'(dp2_ff);
      cr_in  = SW'(cp1_ff) - SW'(cp2_ff);
      sqs_in = SW'(ss1_ff) + SW'(ss2_ff);
      sqe_in = SW'(se1_ff) + SW'(se2_ff);
      // zero-length edge or projection past the end: measure to end vertex
      far_in = (len2 == '0) || (dot_in > len2);
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         far4_ff <= far_in;
         neg4_ff <= dot_in[SW-1];
         cr_ff   <= cr_in;
         sqs_ff  <= sqs_in;
         sqe_ff  <= sqe_in;
      end
   end

   assign cmag_in = cr_ff[SW-1] ? SW'(-cr_ff) : SW'(cr_ff);

   always_ff @(posedge clock) begin
      if (adv.s5) begin
         far5_ff   <= far4_ff;
         neg5_ff   <= neg4_ff;
         nears5_ff <= sqs_ff <= $signed(SW'(epsq));
         neare5_ff <= sqe_ff <= $signed(SW'(epsq));
         // a cross product this large can never lie inside the band
         cbig5_ff  <= |cmag_in[SW-1:CW];
         cabs_ff   <= cmag_in[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s6) begin
         csq_ff    <= cabs_ff * cabs_ff;
         far6_ff   <= far5_ff;
         neg6_ff   <= neg5_ff;
         nears6_ff <= nears5_ff;
         neare6_ff <= neare5_ff;
         cbig6_ff  <= cbig5_ff;
      end
   end

   always_comb begin
      if (far6_ff) begin
         near = neare6_ff;
      end else if (neg6_ff) begin
         near = nears6_ff;
      end else begin
         near = !cbig6_ff && (MW'(csq_ff) <= MW'(rhs));
      end
   end

endmodule

### design/point_in_triangle_tolerance.sv
// Point-in-triangle test with an edge tolerance band.
// Throughput: one point per cycle unless the output stalls; seven pipeline
// stages, each with its own valid bit, so a stalled output only holds the
// stages behind it that are full.
// Reset (synchronous, active high) empties the pipeline, zeroes the vertices
// and sets the tolerance to 26 (0.1 in Q.8).
module point_in_triangle_tolerance #(
   parameter int COORD_BITS = 24,
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_W-1:0]                   req_tdata,  // point_x, point_y
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pitt_pkg::RSP_W-1:0]         rsp_tdata,  // inside_res, is_vertex
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pitt_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [COORD_BITS-1:0]              csr_data
);
   import pitt_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int BW = CB + 2;
   localparam int RW = SW - 1 + EPSQ_BITS;
   localparam int LL = (SW - 1) / 2;
   localparam int LH = SW - 1 - LL;

   // configuration
   logic signed [CB-1:0]       vx_ff [3];
   logic signed [CB-1:0]       vy_ff [3];
   logic [TOL_BITS-1:0]        tol_ff;

   // triangle constants, refreshed every cycle from the configuration
   logic signed [CB-1:0]       mnx_in, mxx_in, mny_in, mxy_in;
   logic signed [BW-1:0]       tol_ext;
   logic signed [BW-1:0]       lox_ff, hix_ff, loy_ff, hiy_ff;
   logic signed [DW-1:0]       evx_ff [3];
   logic signed [DW-1:0]       evy_ff [3];
   logic signed [PW-1:0]       dsqx_ff [3];
   logic signed [PW-1:0]       dsqy_ff [3];
   logic signed [PW-1:0]       dp1_ff, dp2_ff;
   logic [EPSQ_BITS-1:0]       epsq_ff;
   logic signed [SW-1:0]       len2_ff [3];
   logic signed [SW-1:0]       det_ff;
   logic [LL+EPSQ_BITS-1:0]    rlo_ff [3];
   logic [LH+EPSQ_BITS-1:0]    rhi_ff [3];
   logic [RW-1:0]              rhs_ff [3];

   // item pipeline
   logic [7:1]                 v_ff;
   logic [7:1]                 v_in;
   logic [7:1]                 en;
   pitt_adv_type               adv;

   logic signed [CB-1:0]       px_ff, py_ff;
   logic signed [DW-1:0]       qx_ff [3];
   logic signed [DW-1:0]       qy_ff [3];
   logic                       box2_ff, vert2_ff, box_in, vert_in;
   logic signed [PW-1:0]       cvp1_ff, cvp2_ff, cwp1_ff, cwp2_ff;
   logic                       box3_ff, vert3_ff;
   logic signed [SW-1:0]       cv_ff, cw_ff;
   logic                       box4_ff, vert4_ff;
   logic signed [SW:0]         bsum_in, dext_in;
   logic                       bary_in;
   logic                       bary5_ff, box5_ff, vert5_ff;
   logic                       bary6_ff, box6_ff, vert6_ff;
   logic [2:0]                 near;
   logic                       inside_ff, vert7_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
         end
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         case (pitt_csr_type'(csr_index))
            CSR_A_X: vx_ff[0] <= csr_data;
            CSR_A_Y: vy_ff[0] <= csr_data;
            CSR_B_X: vx_ff[1] <= csr_data;
            CSR_B_Y: vy_ff[1] <= csr_data;
            CSR_C_X: vx_ff[2] <= csr_data;
            CSR_C_Y: vy_ff[2] <= csr_data;
            CSR_TOL: tol_ff   <= csr_data[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------ derived constants
   always_comb begin
      mnx_in = vx_ff[0];
      mxx_in = vx_ff[0];
      mny_in = vy_ff[0];
      mxy_in = vy_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (vx_ff[i] < mnx_in) mnx_in = vx_ff[i];
         if (vx_ff[i] > mxx_in) mxx_in = vx_ff[i];
         if (vy_ff[i] < mny_in) mny_in = vy_ff[i];
         if (vy_ff[i] > mxy_in) mxy_in = vy_ff[i];
      end
      tol_ext = BW'($signed({1'b0, tol_ff}));
   end

   always_ff @(posedge clock) begin
      lox_ff  <= BW'(mnx_in) - tol_ext;
      hix_ff  <= BW'(mxx_in) + tol_ext;
      loy_ff  <= BW'(mny_in) - tol_ext;
      hiy_ff  <= BW'(mxy_in) + tol_ext;
      epsq_ff <= tol_ff * tol_ff;
      // determinant of (B - A, C - A), with C - A = -(edge CA)
      dp1_ff  <= evy_ff[0] * evx_ff[2];
      dp2_ff  <= evx_ff[0] * evy_ff[2];
      det_ff  <= SW'(dp1_ff) - SW'(dp2_ff);
   end

   for (genvar i = 0; i < 3; i++) begin : g_edge_const
      always_ff @(posedge clock) begin
         evx_ff[i]  <= DW'(vx_ff[(i + 1) % 3]) - DW'(vx_ff[i]);
         evy_ff[i]  <= DW'(vy_ff[(i + 1) % 3]) - DW'(vy_ff[i]);
         dsqx_ff[i] <= evx_ff[i] * evx_ff[i];
         dsqy_ff[i] <= evy_ff[i] * evy_ff[i];
         len2_ff[i] <= SW'(dsqx_ff[i]) + SW'(dsqy_ff[i]);
         // split eps^2 * len2 into two half-width products
         rlo_ff[i]  <= epsq_ff * len2_ff[i][LL-1:0];
         rhi_ff[i]  <= epsq_ff * len2_ff[i][SW-2:LL];
         rhs_ff[i]  <= (RW'(rhi_ff[i]) << LL) + RW'(rlo_ff[i]);
      end
   end

   // ---------------------------------------------------------- flow control
   always_comb begin
      en[7] = !v_ff[7] || rsp_tready;
      for (int k = 6; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1];
   assign v_in       = {v_ff[6:1], req_tvalid};
   assign adv        = '{s3: en[3], s4: en[4], s5: en[5], s6: en[6]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= 7; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   // ---------------------------------------------------------------- stages
   always_ff @(posedge clock) begin
      if (en[1]) begin
         px_ff <= req_tdata[CB-1:0];
         py_ff <= req_tdata[2*CB-1:CB];
      end
   end

   always_comb begin
      box_in = (BW'(px_ff) >= lox_ff) && (BW'(px_ff) <= hix_ff) &&
               (BW'(py_ff) >= loy_ff) && (BW'(py_ff) <= hiy_ff);
      vert_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (px_ff == vx_ff[i] && py_ff == vy_ff[i]) vert_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            qx_ff[i] <= DW'(px_ff) - DW'(vx_ff[i]);
            qy_ff[i] <= DW'(py_ff) - DW'(vy_ff[i]);
         end
         box2_ff  <= box_in;
         vert2_ff <= vert_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         cvp1_ff  <= qy_ff[0] * evx_ff[2];
         cvp2_ff  <= qx_ff[0] * evy_ff[2];
         cwp1_ff  <= evx_ff[0] * qy_ff[0];
         cwp2_ff  <= evy_ff[0] * qx_ff[0];
         box3_ff  <= box2_ff;
         vert3_ff <= vert2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         cv_ff    <= SW'(cvp1_ff) - SW'(cvp2_ff);
         cw_ff    <= SW'(cwp1_ff) - SW'(cwp2_ff);
         box4_ff  <= box3_ff;
         vert4_ff <= vert3_ff;
      end
   end

   // barycentric test by cross products; a degenerate triangle never passes
   always_comb begin
      bsum_in = (SW+1)'(cv_ff) + (SW+1)'(cw_ff);
      dext_in = (SW+1)'(det_ff);
      if (det_ff == '0) begin
         bary_in = 1'b0;
      end else if (!det_ff[SW-1]) begin
         bary_in = !cv_ff[SW-1] && !cw_ff[SW-1] && (bsum_in <= dext_in);
      end else begin
         bary_in = (cv_ff[SW-1] || cv_ff == '0) && (cw_ff[SW-1] || cw_ff == '0) &&
                   (bsum_in >= dext_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         bary5_ff <= bary_in;
         box5_ff  <= box4_ff;
         vert5_ff <= vert4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         bary6_ff <= bary5_ff;
         box6_ff  <= box5_ff;
         vert6_ff <= vert5_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_edge
      pitt_edge #(
         .COORD_BITS(COORD_BITS)
      ) u_edge (
         .clock (clock),
         .adv   (adv),
         .qs_x  (qx_ff[i]),
         .qs_y  (qy_ff[i]),
         .qe_x  (qx_ff[(i + 1) % 3]),
         .qe_y  (qy_ff[(i + 1) % 3]),
         .ev_x  (evx_ff[i]),
         .ev_y  (evy_ff[i]),
         .len2  (len2_ff[i]),
         .epsq  (epsq_ff),
         .rhs   (rhs_ff[i]),
         .near  (near[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         inside_ff <= box6_ff && (bary6_ff || (|near));
         vert7_ff  <= vert6_ff;
      end
   end

   assign rsp_tvalid = v_ff[7];
   assign rsp_tdata  = {(RSP_W - 2)'(0), vert7_ff, inside_ff};

   // ------------------------------------------------------------ assertions
   // an empty pipeline always takes a transfer
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (v_ff == '0) |-> req_tready)
      else $error("empty pipeline refused an input transfer");

   // a point on a vertex lies on the edges that meet there, so it must be reported inside
   a_vertex_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("vertex hit reported outside the triangle");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented right after reset");

endmodule

### sim/testbench.sv
module testbench;
   import pitt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 24;
   localparam int REQ_W = ((2 * CB + 7) / 8) * 8;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      logic inside_res;
      logic is_vertex;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CB-1:0] csr_data = '0;

   // Predictor copy of the registers
   coord_type tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy;
   logic [7:0] tol;

   verdict_type verdict_q[$];
   int errors = 0;
   longint cycles = 0;
   bit stim_done = 0;
   bit hold_off = 0;
   bit no_idle = 0;

   point_in_triangle_tolerance #(.COORD_BITS(CB)) u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic sq_le(longint dx, longint dy, longint e);
      logic signed [127:0] d;
      d = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      return d <= 128'(e) * 128'(e);
   endfunction

   function automatic logic near_edge(longint sx, longint sy, longint ex, longint ey,
                                      longint px, longint py, longint e);
      logic signed [127:0] len2, dotp, cr;
      longint dx, dy, qx, qy;
      dx = ex - sx; dy = ey - sy; qx = px - sx; qy = py - sy;
      len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      dotp = 128'(qx) * 128'(dx) + 128'(qy) * 128'(dy);
      if (len2 == 0 || dotp > len2) return sq_le(px - ex, py - ey, e);
      if (dotp < 0) return sq_le(qx, qy, e);
      cr = 128'(dx) * 128'(qy) - 128'(dy) * 128'(qx);
      if (cr < 0) cr = -cr;
      // |cross| fits 64 bits here, so its square fits 128
      return cr * cr <= 128'(e) * 128'(e) * len2;
   endfunction

   function automatic verdict_type classify_point(coord_type px_c, coord_type py_c);
      verdict_type r;
      longint ax, ay, bx, by, cx, cy, px, py, e, mnx, mxx, mny, mxy;
      logic signed [127:0] d, cv, cw;
      logic ins;
      ax = tri_ax; ay = tri_ay; bx = tri_bx; by = tri_by; cx = tri_cx; cy = tri_cy;
      px = px_c; py = py_c; e = tol;
      mnx = ax < bx ? ax : bx; if (cx < mnx) mnx = cx;
      mxx = ax > bx ? ax : bx; if (cx > mxx) mxx = cx;
      mny = ay < by ? ay : by; if (cy < mny) mny = cy;
      mxy = ay > by ? ay : by; if (cy > mxy) mxy = cy;
      ins = 0;
      if (!(px < mnx - e || px > mxx + e || py < mny - e || py > mxy + e)) begin
         d = 128'(bx - ax) * 128'(cy - ay) - 128'(by - ay) * 128'(cx - ax);
         cv = 128'(px - ax) * 128'(cy - ay) - 128'(py - ay) * 128'(cx - ax);
         cw = 128'(bx - ax) * 128'(py - ay) - 128'(by - ay) * 128'(px - ax);
         if (d > 0) ins = cv >= 0 && cw >= 0 && cv + cw <= d;
         else if (d < 0) ins = cv <= 0 && cw <= 0 && cv + cw >= d;
         if (!ins)
            ins = near_edge(ax, ay, bx, by, px, py, e) ||
                  near_edge(bx, by, cx, cy, px, py, e) ||
                  near_edge(cx, cy, ax, ay, px, py, e);
      end
      r.inside_res = ins;
      r.is_vertex = (px == ax && py == ay) || (px == bx && py == by) ||
                    (px == cx && py == cy);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Hold valid across back-to-back writes; the caller drops it
   task automatic csr_write(pitt_csr_type idx, logic [CB-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_A_X: tri_ax = val;
         CSR_A_Y: tri_ay = val;
         CSR_B_X: tri_bx = val;
         CSR_B_Y: tri_by = val;
         CSR_C_X: tri_cx = val;
         CSR_C_Y: tri_cy = val;
         CSR_TOL: tol = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_triangle(coord_type ax, coord_type ay, coord_type bx, coord_type by,
                               coord_type cx, coord_type cy, logic [7:0] e);
      csr_write(CSR_A_X, ax); csr_write(CSR_A_Y, ay);
      csr_write(CSR_B_X, bx); csr_write(CSR_B_Y, by);
      csr_write(CSR_C_X, cx); csr_write(CSR_C_Y, cy);
      csr_write(CSR_TOL, {16'd0, e});
      csr_valid <= 1'b0;
   endtask

   // Send one point; drop valid only when the next item is not immediate
   task automatic send_point(coord_type px, coord_type py, bit chk_fixed,
                             verdict_type fixed);
      verdict_type v;
      while (!no_idle && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      v = classify_point(px, py);
      if (chk_fixed && v != fixed) report_mismatch("directed row", v, fixed);
      req_tvalid <= 1'b1;
      req_tdata <= {py, px};
      do @(posedge clock); while (!req_tready);
      verdict_q.push_back(v);
   endtask

   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic coord_type near_coord(coord_type base);
      int r;
      r = $urandom_range(7);
      if (r == 0) return coord_type'($urandom);
      return base + coord_type'($signed($urandom_range(1200)) - 600);
   endfunction

   typedef struct {
      coord_type px, py;
      bit chk;
      verdict_type want;
   } point_row_type;

   // Result checker
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = verdict_type'({rsp_tdata[0], rsp_tdata[1]});
         if (verdict_q.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = verdict_q.pop_front();
            if (got.inside_res !== want.inside_res)
               report_mismatch("inside_res", got.inside_res, want.inside_res);
            if (got.is_vertex !== want.is_vertex)
               report_mismatch("is_vertex", got.is_vertex, want.is_vertex);
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= no_idle || stim_done || ($urandom_range(99) >= 22);
   end

   initial begin
      point_row_type rows[$];
      coord_type vmin, vmax;
      vmin = coord_type'(24'h800000);
      vmax = coord_type'(24'h7FFFFF);
      tri_ax = 0; tri_ay = 0; tri_bx = 0; tri_by = 0; tri_cx = 0; tri_cy = 0;
      tol = TOL_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset triangle collapses to the origin: only points within tol pass
      rows.push_back('{0, 0, 1, 2'b11});
      rows.push_back('{26, 0, 1, 2'b10});
      rows.push_back('{27, 0, 1, 2'b00});
      rows.push_back('{vmax, vmin, 1, 2'b00});
      rows.push_back('{vmin, vmax, 1, 2'b00});
      foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].chk, rows[i].want);
      drain_pipe();

      rows.delete();
      set_triangle(0, 0, 2560, 0, 0, 2560, 8'd0);
      rows.push_back('{0, 0, 1, 2'b11});
      rows.push_back('{2560, 0, 1, 2'b11});
      rows.push_back('{256, 256, 1, 2'b10});
      rows.push_back('{1280, 1280, 1, 2'b10});
      rows.push_back('{1281, 1280, 1, 2'b00});
      rows.push_back('{-1, 0, 1, 2'b00});
      rows.push_back('{3000, 3000, 0, 2'b00});
      foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].chk, rows[i].want);
      drain_pipe();

      // Degenerate (collinear, coincident) and extreme-corner triangles; max tol but for coincident
      rows.delete();
      set_triangle(0, 0, 1000, 1000, 2000, 2000, 8'd255);
      rows.push_back('{500, 500, 0, 0});
      rows.push_back('{500, 700, 0, 0});
      rows.push_back('{2200, 2200, 0, 0});
      rows.push_back('{-180, -180, 0, 0});
      foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].chk, rows[i].want);
      drain_pipe();
      rows.delete();
      set_triangle(vmin, vmin, vmax, vmin, vmin, vmax, 8'd255);
      rows.push_back('{vmin, vmin, 1, 2'b11});
      rows.push_back('{vmax, vmax, 0, 0});
      rows.push_back('{0, 0, 0, 0});
      rows.push_back('{vmax, vmin, 1, 2'b11});
      foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].chk, rows[i].want);
      drain_pipe();
      set_triangle(500, 500, 500, 500, 500, 500, 8'd10);
      send_point(500, 510, 0, 0);
      send_point(500, 511, 0, 0);
      send_point(-500, 300, 0, 0);
      drain_pipe();

      // Random phases, each with a fresh triangle
      for (int ph = 0; ph < 9; ph++) begin
         coord_type ax, ay;
         int span;
         span = (ph == 4) ? 8000000 : $urandom_range(4000) + 1;
         ax = (ph == 4) ? coord_type'(0) : coord_type'($urandom);
         ay = (ph == 4) ? coord_type'(0) : coord_type'($urandom);
         set_triangle(ax, ay,
                      ax + coord_type'($signed($urandom_range(2 * span)) - span),
                      ay + coord_type'($signed($urandom_range(2 * span)) - span),
                      (ph == 7) ? ax :
                         ax + coord_type'($signed($urandom_range(2 * span)) - span),
                      (ph == 7) ? ay :
                         ay + coord_type'($signed($urandom_range(2 * span)) - span),
                      (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom));
         no_idle = (ph == 3);
         if (ph == 5) begin
            fork
               begin
                  hold_off = 1;
                  repeat (60) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         for (int k = 0; k < 100; k++) begin
            coord_type px, py;
            case ($urandom_range(9))
               0: begin px = coord_type'($urandom); py = coord_type'($urandom); end
               1: begin px = tri_bx; py = tri_by; end
               2: begin
                  px = tri_ax + (tri_cx - tri_ax) / 2 +
                       coord_type'($signed($urandom_range(6)) - 3);
                  py = tri_ay + (tri_cy - tri_ay) / 2 +
                       coord_type'($signed($urandom_range(6)) - 3);
               end
               default: begin
                  px = (ph == 4) ? coord_type'($urandom) : near_coord(tri_ax);
                  py = (ph == 4) ? coord_type'($urandom) : near_coord(tri_ay);
               end
            endcase
            send_point(px, py, 0, 0);
         end
         no_idle = 0;
         drain_pipe();
      end

      stim_done = 1;
      repeat (20) @(posedge clock);
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
